// ===== src/button_click_classifier_unit_assert.svh =====
// assertion macros used by the click classifier rtl
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bcc_pkg.sv =====
// types, codes and constants of the button click classifier
package bcc_pkg;

  localparam int TIME_W     = 32;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int NUM_KEYS_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DCW_IDX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LPT_IDX = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0] DCW_RST = THR_W'(400);
  localparam logic [THR_W-1:0] LPT_RST = THR_W'(800);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_WAIT    = 2'd2,
    PH_LONG    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_SINGLE = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_LONG   = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic [1:0]        key_index;
    logic [TIME_W-1:0] now_ms;
    logic              press_edge;
    logic              released;
  } in_word_t;

  typedef struct packed {
    logic [1:0] event_key;
    logic [1:0] event_kind;
  } out_word_t;

  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] release_time;
    logic              suppress;
  } key_state_t;

  localparam key_state_t KEY_STATE_RST = '{
    phase:        PH_IDLE,
    press_time:   '0,
    release_time: '0,
    suppress:     1'b1
  };

endpackage

// ===== src/bcc_ram.sv =====
// generic single-port-write ram with registered read
module bcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bcc_classify.sv =====
// per-key next-state and event logic for one poll
module bcc_classify (
  input  bcc_pkg::key_state_t              cur_state,
  input  logic [bcc_pkg::TIME_W-1:0]       now_ms,
  input  logic                             press_edge,
  input  logic                             released,
  input  logic [bcc_pkg::THR_W-1:0]        dcw,
  input  logic [bcc_pkg::THR_W-1:0]        lpt,
  output bcc_pkg::key_state_t              nxt_state,
  output logic                             fire,
  output bcc_pkg::ev_kind_t                kind
);
  import bcc_pkg::*;

  logic [TIME_W-1:0] el_press;
  logic [TIME_W-1:0] el_rel;
  logic              in_window;
  logic              past_window;
  logic              held_long;

  // modular elapsed times against stored marks
  assign el_press    = now_ms - cur_state.press_time;
  assign el_rel      = now_ms - cur_state.release_time;
  assign in_window   = el_rel < TIME_W'(dcw);
  assign past_window = el_rel > TIME_W'(dcw);
  assign held_long   = el_press > TIME_W'(lpt);

  always_comb begin
    phase_t ph;
    logic   started;
    logic   rel_now;
    ph        = cur_state.phase;
    started   = 1'b0;
    rel_now   = 1'b0;
    nxt_state = cur_state;
    fire      = 1'b0;
    kind      = EV_SINGLE;

    if (press_edge) begin
      if (ph == PH_IDLE) begin
        nxt_state.press_time = now_ms;
        nxt_state.suppress   = 1'b0;
        ph                   = PH_PRESSED;
        started              = 1'b1;
      end else if (ph == PH_WAIT && in_window) begin
        fire               = 1'b1;
        kind               = EV_DOUBLE;
        nxt_state.suppress = 1'b1;
        ph                 = PH_IDLE;
      end
    end

    // a press started on this poll has zero hold time
    if (ph == PH_PRESSED && !started && held_long) begin
      fire               = 1'b1;
      kind               = EV_LONG;
      nxt_state.suppress = 1'b1;
      ph                 = PH_LONG;
    end

    if (released) begin
      if (ph == PH_PRESSED) begin
        nxt_state.release_time = now_ms;
        ph                     = PH_WAIT;
        rel_now                = 1'b1;
      end else if (ph == PH_LONG) begin
        ph = PH_IDLE;
      end
    end

    // a release on this poll has zero wait time
    if (ph == PH_WAIT && !rel_now && past_window) begin
      if (!nxt_state.suppress) begin
        fire = 1'b1;
        kind = EV_SINGLE;
      end
      ph = PH_IDLE;
    end

    nxt_state.phase = ph;
  end

endmodule

// ===== src/button_click_classifier_unit.sv =====
// Click classifier for up to NUM_KEYS keys: each input word is one poll of one key, and each
// poll gives zero or one output word (single click, double click or long press). One word is
// accepted every cycle, stalls aside; a result is held in the classifier stage register and then
// in the output register. The per-key state lives in a small ram read when a poll is accepted
// and written by the classifier stage as the poll leaves it, with a bypass so that polls of the
// same key may follow back to back. Per-key valid bits give the reset state without a
// clearing pass. Thresholds are written on the cfg port: index 0 is the double-click window,
// index 1 the long press time, both in milliseconds; other indexes are ignored.
`include "button_click_classifier_unit_assert.svh"

module button_click_classifier_unit #(
  parameter int NUM_KEYS = bcc_pkg::NUM_KEYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bcc_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bcc_pkg::out_word_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcc_pkg::THR_W-1:0]        cfg_data
);
  import bcc_pkg::*;

  localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int ST_W   = $bits(key_state_t);

  logic [THR_W-1:0]    dcw_r;
  logic [THR_W-1:0]    lpt_r;
  logic [NUM_KEYS-1:0] key_vld_r;

  logic                s1_valid_r;
  in_word_t            s1_word_r;
  logic                s1_inrange_r;
  logic                s1_kvld_r;
  logic                s1_fwd_r;
  key_state_t          s1_fwd_state_r;

  logic                out_valid_r;
  out_word_t           out_word_r;

  logic                out_free;
  logic                s1_adv;
  logic                in_acc;
  logic                in_range;
  logic [KEY_AW-1:0]   rd_addr;
  logic [KEY_AW-1:0]   wr_addr;
  logic                wr_en;
  logic [ST_W-1:0]     ram_rdata;
  key_state_t          cur_state;
  key_state_t          nxt_state;
  logic                fire;
  ev_kind_t            kind;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign in_range = int'(in_data.key_index) < NUM_KEYS;
  assign rd_addr  = KEY_AW'(in_data.key_index);
  assign wr_addr  = KEY_AW'(s1_word_r.key_index);
  assign wr_en    = s1_adv && s1_inrange_r;

  bcc_ram #(
    .WIDTH (ST_W),
    .DEPTH (NUM_KEYS)
  ) u_state_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (nxt_state),
    .rd_en     (in_acc),
    .rd_addr   (rd_addr),
    .rd_data_r (ram_rdata)
  );

  // bypass beats the ram, and never-written keys read as reset state
  always_comb begin
    if (s1_fwd_r) begin
      cur_state = s1_fwd_state_r;
    end else if (s1_kvld_r) begin
      cur_state = key_state_t'(ram_rdata);
    end else begin
      cur_state = KEY_STATE_RST;
    end
  end

  bcc_classify u_classify (
    .cur_state  (cur_state),
    .now_ms     (s1_word_r.now_ms),
    .press_edge (s1_word_r.press_edge),
    .released   (s1_word_r.released),
    .dcw        (dcw_r),
    .lpt        (lpt_r),
    .nxt_state  (nxt_state),
    .fire       (fire),
    .kind       (kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcw_r       <= DCW_RST;
      lpt_r       <= LPT_RST;
      key_vld_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DCW_IDX) begin
          dcw_r <= cfg_data;
        end else if (cfg_index == CFG_LPT_IDX) begin
          lpt_r <= cfg_data;
        end
      end
      if (wr_en) begin
        key_vld_r[wr_addr] <= 1'b1;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r && s1_inrange_r && fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r      <= in_data;
      s1_inrange_r   <= in_range;
      s1_kvld_r      <= in_range && key_vld_r[rd_addr];
      s1_fwd_r       <= wr_en && (wr_addr == rd_addr);
      s1_fwd_state_r <= nxt_state;
    end
    if (s1_adv) begin
      out_word_r.event_key  <= s1_word_r.key_index;
      out_word_r.event_kind <= kind;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  `BCC_ASSERT_NEXT(a_s1_hold, s1_valid_r && !out_free,
    s1_valid_r && $stable(s1_word_r), "classifier stage lost its word while stalled")
  `BCC_ASSERT_NOW(a_wr_on_adv, wr_en, s1_valid_r && out_free && s1_inrange_r,
    "key state written without the stage advancing")
  `BCC_ASSERT_NEXT(a_bypass, in_acc && wr_en && (wr_addr == rd_addr), s1_fwd_r,
    "same-key poll did not take the bypass")
  `BCC_ASSERT_NOW(a_wait_unsuppressed, wr_en && (nxt_state.phase == PH_WAIT),
    !nxt_state.suppress, "key waiting for second press with single click suppressed")

endmodule
